FILE: hdl/grid_ray_dda_traversal_defines.svh
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal assertion macros
// Shorthand for clocked assertions; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH
`define GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH

`ifndef SYNTH
`define GRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define GRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define GRD_ASSERT_IMP(lbl, ante, cons, msg)
`define GRD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/grdda_pkg.sv
// ----------------------------------------------------------------------------
// grdda_pkg
// Types and constants of the grid ray caster.
// ----------------------------------------------------------------------------
package grdda_pkg;

	localparam int MAP_DIM_DEF        = 32;
	localparam int MAX_STEP_LIMIT_DEF = 255;

	localparam logic [23:0] DIST_SAT = 24'hFF_FFFF;

	localparam logic [5:0] MAP_COLUMNS_RST = 6'd24;
	localparam logic [5:0] MAP_ROWS_RST    = 6'd24;
	localparam logic [7:0] STEP_LIMIT_RST  = 8'd100;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef enum logic [1:0] {
		CFG_MAP_COLUMNS = 2'd0,
		CFG_MAP_ROWS    = 2'd1,
		CFG_STEP_LIMIT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/grid_ray_dda_traversal.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal
// 2-D DDA ray caster over a wall bitmap held in flops.
// ----------------------------------------------------------------------------
// One item at a time. A map row write goes to the done state and then to the
// output register. A cast runs a shared restoring divider that forms the
// two reciprocal step distances at one quotient bit per cycle, one axis
// after the other; then one shared 11x24 multiplier sets the first boundary
// distances, then the walker takes one cell step per cycle until a wall is hit
// or the step limit is reached. Results sit in an output register.
`include "grid_ray_dda_traversal_defines.svh"

module grid_ray_dda_traversal #(
	parameter int MAP_DIM        = grdda_pkg::MAP_DIM_DEF,
	parameter int MAX_STEP_LIMIT = grdda_pkg::MAX_STEP_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [4:0]         row_select,
	input  logic [31:0]        row_walls,
	input  logic [15:0]        start_x,
	input  logic [15:0]        start_y,
	input  logic signed [15:0] heading_x,
	input  logic signed [15:0] heading_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               wall_hit,
	output logic               hit_side,
	output logic [23:0]        wall_distance,
	output logic signed [9:0]  hit_cell_x,
	output logic signed [9:0]  hit_cell_y,
	output logic [7:0]         steps_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int RIDX   = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
	localparam int LIM_W  = $clog2(MAX_STEP_LIMIT + 1);
	localparam int CELL_W = $clog2(MAX_STEP_LIMIT + 64) + 1;

	grdda_pkg::state_t state_q, state_d;

	logic [31:0] map_q [MAP_DIM];
	logic [5:0]  map_columns_q, map_rows_q;
	logic [7:0]  step_limit_q;

	logic               axis_q;
	logic               wr_q;
	logic [4:0]         cnt_q;
	logic [15:0]        rem_q;
	logic [23:0]        quo_q;
	logic [15:0]        hx_q, hy_q;
	logic [9:0]         fx_q, fy_q;
	logic [23:0]        dx_q, dy_q, ax_q, ay_q, dist_q;
	logic signed [CELL_W-1:0] gx_q, gy_q;
	logic [LIM_W-1:0]   steps_q;
	logic               hit_q, side_q;
	logic               out_valid_q;

	logic accept, div_last, walk_end, out_free;
	logic load_cast, load_write, div_en, mul_en, walk_en, out_load;

	// effective configuration
	logic [10:0]        lim_w;
	logic [LIM_W-1:0]   lim_eff;
	logic [5:0]         cols6;
	logic [6:0]         rows7;
	logic signed [CELL_W-1:0] cols_s, rows_s;

	assign lim_w   = (11'(step_limit_q) > 11'(MAX_STEP_LIMIT)) ? 11'(MAX_STEP_LIMIT)
		: 11'(step_limit_q);
	assign lim_eff = lim_w[LIM_W-1:0];
	assign cols6   = (map_columns_q > 6'd32) ? 6'd32 : map_columns_q;
	assign rows7   = (7'(map_rows_q) > 7'(MAP_DIM)) ? 7'(MAP_DIM) : 7'(map_rows_q);
	assign cols_s  = $signed(CELL_W'(cols6));
	assign rows_s  = $signed(CELL_W'(rows7));

	// divider
	logic [15:0] hsel, mag;
	logic [16:0] rs, rsub;
	logic        ge;
	logic [24:0] quo_next;
	logic [23:0] delta_new;

	assign hsel      = (axis_q == grdda_pkg::AXIS_Y) ? hy_q : hx_q;
	assign mag       = hsel[15] ? (~hsel + 16'd1) : hsel;
	assign rs        = {rem_q, (cnt_q == 5'd24)};
	assign ge        = rs >= {1'b0, mag};
	assign rsub      = rs - {1'b0, mag};
	assign quo_next  = {quo_q, ge};
	assign delta_new = quo_next[24] ? grdda_pkg::DIST_SAT : quo_next[23:0];

	// multiplier
	logic [9:0]  fsel;
	logic [23:0] dsel;
	logic [10:0] part;
	logic [34:0] prod;
	logic [23:0] first_d;

	assign fsel    = (axis_q == grdda_pkg::AXIS_Y) ? fy_q : fx_q;
	assign dsel    = (axis_q == grdda_pkg::AXIS_Y) ? dy_q : dx_q;
	assign part    = hsel[15] ? {1'b0, fsel} : (11'd1024 - {1'b0, fsel});
	assign prod    = 35'(part) * 35'(dsel);
	assign first_d = prod[34] ? grdda_pkg::DIST_SAT : prod[33:10];

	// walker
	logic step_x, wall_x, wall_y;
	logic signed [CELL_W-1:0] nx, ny;
	logic [24:0] sum_x, sum_y;
	logic [23:0] ax_n, ay_n;

	function automatic logic cell_wall(input logic signed [CELL_W-1:0] cx,
		input logic signed [CELL_W-1:0] cy, input logic [31:0] row,
		input logic signed [CELL_W-1:0] cl, input logic signed [CELL_W-1:0] rw);
		cell_wall = (cx >= 0) && (cy >= 0) && (cx < cl) && (cy < rw) && row[cx[4:0]];
	endfunction

	assign step_x = ax_q < ay_q;
	assign nx     = hx_q[15] ? (gx_q - $signed(CELL_W'(1))) : (gx_q + $signed(CELL_W'(1)));
	assign ny     = hy_q[15] ? (gy_q - $signed(CELL_W'(1))) : (gy_q + $signed(CELL_W'(1)));
	assign sum_x  = {1'b0, ax_q} + {1'b0, dx_q};
	assign sum_y  = {1'b0, ay_q} + {1'b0, dy_q};
	assign ax_n   = sum_x[24] ? grdda_pkg::DIST_SAT : sum_x[23:0];
	assign ay_n   = sum_y[24] ? grdda_pkg::DIST_SAT : sum_y[23:0];
	assign wall_x = cell_wall(nx, gy_q, map_q[gy_q[RIDX-1:0]], cols_s, rows_s);
	assign wall_y = cell_wall(gx_q, ny, map_q[ny[RIDX-1:0]], cols_s, rows_s);

	assign accept   = in_valid && !in_stall;
	assign div_last = cnt_q == 5'd0;
	assign walk_end = hit_q || (steps_q >= lim_eff);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grdda_pkg::ST_IDLE: begin
				if (accept)
					state_d = (opcode == grdda_pkg::OP_CAST) ? grdda_pkg::ST_DIV
						: grdda_pkg::ST_DONE;
			end
			grdda_pkg::ST_DIV: begin
				if (div_last && axis_q == grdda_pkg::AXIS_Y)
					state_d = grdda_pkg::ST_MUL;
			end
			grdda_pkg::ST_MUL: begin
				if (axis_q == grdda_pkg::AXIS_Y)
					state_d = grdda_pkg::ST_WALK;
			end
			grdda_pkg::ST_WALK: begin
				if (walk_end)
					state_d = grdda_pkg::ST_DONE;
			end
			grdda_pkg::ST_DONE: begin
				if (out_free)
					state_d = grdda_pkg::ST_IDLE;
			end
			default: state_d = grdda_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall   = 1'b1;
		load_cast  = 1'b0;
		load_write = 1'b0;
		div_en     = 1'b0;
		mul_en     = 1'b0;
		walk_en    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			grdda_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				load_cast  = accept && (opcode == grdda_pkg::OP_CAST);
				load_write = accept && (opcode == grdda_pkg::OP_WRITE);
			end
			grdda_pkg::ST_DIV:  div_en = 1'b1;
			grdda_pkg::ST_MUL:  mul_en = 1'b1;
			grdda_pkg::ST_WALK: walk_en = !walk_end;
			grdda_pkg::ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= grdda_pkg::ST_IDLE;
			map_columns_q <= grdda_pkg::MAP_COLUMNS_RST;
			map_rows_q    <= grdda_pkg::MAP_ROWS_RST;
			step_limit_q  <= grdda_pkg::STEP_LIMIT_RST;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < MAP_DIM; i++)
				map_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					grdda_pkg::CFG_MAP_COLUMNS: map_columns_q <= cfg_data[5:0];
					grdda_pkg::CFG_MAP_ROWS:    map_rows_q    <= cfg_data[5:0];
					grdda_pkg::CFG_STEP_LIMIT:  step_limit_q  <= cfg_data;
					default: ;
				endcase
			end
			if (load_write && ({27'd0, row_select} < 32'(MAP_DIM)))
				map_q[RIDX'(row_select)] <= row_walls;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cast || load_write) begin
			wr_q    <= load_write;
			axis_q  <= grdda_pkg::AXIS_X;
			cnt_q   <= 5'd24;
			rem_q   <= '0;
			hx_q    <= heading_x;
			hy_q    <= heading_y;
			fx_q    <= start_x[9:0];
			fy_q    <= start_y[9:0];
			gx_q    <= load_cast ? $signed(CELL_W'(start_x[15:10])) : '0;
			gy_q    <= load_cast ? $signed(CELL_W'(start_y[15:10])) : '0;
			steps_q <= '0;
			hit_q   <= 1'b0;
			side_q  <= 1'b0;
			dist_q  <= '0;
		end
		if (div_en) begin
			quo_q <= quo_next[23:0];
			if (div_last) begin
				rem_q  <= '0;
				cnt_q  <= 5'd24;
				axis_q <= ~axis_q;
				if (axis_q == grdda_pkg::AXIS_Y)
					dy_q <= delta_new;
				else
					dx_q <= delta_new;
			end else begin
				rem_q <= ge ? rsub[15:0] : rs[15:0];
				cnt_q <= cnt_q - 5'd1;
			end
		end
		if (mul_en) begin
			axis_q <= ~axis_q;
			if (axis_q == grdda_pkg::AXIS_Y)
				ay_q <= first_d;
			else
				ax_q <= first_d;
		end
		if (walk_en) begin
			steps_q <= steps_q + LIM_W'(1);
			if (step_x) begin
				ax_q <= ax_n;
				gx_q <= nx;
				if (wall_x) begin
					hit_q  <= 1'b1;
					side_q <= 1'b0;
					dist_q <= ax_q;
				end
			end else begin
				ay_q <= ay_n;
				gy_q <= ny;
				if (wall_y) begin
					hit_q  <= 1'b1;
					side_q <= 1'b1;
					dist_q <= ay_q;
				end
			end
		end
		if (out_load) begin
			wall_hit      <= hit_q;
			hit_side      <= hit_q && side_q;
			wall_distance <= wr_q ? 24'd0 : (hit_q ? dist_q : grdda_pkg::DIST_SAT);
			hit_cell_x    <= 10'(gx_q);
			hit_cell_y    <= 10'(gy_q);
			steps_used    <= 8'(steps_q);
		end
	end

	assign out_valid = out_valid_q;

	`GRD_ASSERT_IMP(a_nohit_sat, out_valid && !wall_hit && !hit_side && wall_distance != 24'd0, wall_distance == grdda_pkg::DIST_SAT, "miss must report saturated distance")
	`GRD_ASSERT_IMP(a_steps_cap, state_q == grdda_pkg::ST_WALK, steps_q <= lim_eff, "step count above limit")
	`GRD_ASSERT_NXT(a_step_inc, walk_en, steps_q == $past(steps_q) + LIM_W'(1), "walker step not counted")
	`GRD_ASSERT_IMP(a_side_hit, out_valid && hit_side, wall_hit, "side set without hit")

endmodule

FILE: tb/sv/grid_ray_dda_traversal_tb.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal_tb
// Self-checking bench for the grid ray caster: loads wall maps, casts
// directed and random rays under several register settings, with random
// idling on both channels and one long output hold-off, and compares every
// result beat with an in-bench DDA predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_ray_dda_traversal_tb;

	localparam int          N_RANDOM  = 830;
	localparam int          MAX_CYCLE = 2000000;
	localparam logic [23:0] SAT       = grdda_pkg::DIST_SAT;

	typedef struct packed {
		logic        op;
		logic [4:0]  row;
		logic [31:0] walls;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] hx;
		logic [15:0] hy;
	} ray_req_t;

	typedef struct packed {
		logic        hit;
		logic        side;
		logic [23:0] wdist;
		logic [9:0]  cx;
		logic [9:0]  cy;
		logic [7:0]  steps;
	} ray_res_t;

	typedef struct {
		ray_req_t req;
		logic     known;
		ray_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = grdda_pkg::OP_WRITE;
	logic [4:0] row_select = '0;
	logic [31:0] row_walls = '0;
	logic [15:0] start_x = '0;
	logic [15:0] start_y = '0;
	logic signed [15:0] heading_x = '0;
	logic signed [15:0] heading_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic wall_hit;
	logic hit_side;
	logic [23:0] wall_distance;
	logic signed [9:0] hit_cell_x;
	logic signed [9:0] hit_cell_y;
	logic [7:0] steps_used;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = grdda_pkg::CFG_MAP_COLUMNS;
	logic [7:0] cfg_data = '0;

	grid_ray_dda_traversal uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [31:0] pm_map [32];
	logic [5:0]  pm_cols;
	logic [5:0]  pm_rows;
	logic [7:0]  pm_limit;

	ray_res_t expected_q [$];
	int errors = 0;
	int n_hits = 0;
	int n_beats = 0;
	int n_casts = 0;
	int cycle = 0;
	logic no_idle = 1'b0;
	logic hold_rx = 1'b0;

	function automatic logic [23:0] recip(logic [15:0] h);
		logic [15:0] mag;
		logic [24:0] q;
		mag = h[15] ? -h : h;
		if (mag == 0)
			return SAT;
		q = 25'h100_0000 / mag;
		return (q > SAT) ? SAT : q[23:0];
	endfunction

	function automatic logic [23:0] sadd(logic [23:0] a, logic [23:0] b);
		logic [24:0] s;
		s = a + b;
		return (s > SAT) ? SAT : s[23:0];
	endfunction

	function automatic logic is_wall(int gx, int gy);
		int c;
		int r;
		c = (pm_cols > 32) ? 32 : pm_cols;
		r = (pm_rows > 32) ? 32 : pm_rows;
		if (gx < 0 || gy < 0 || gx >= c || gy >= r)
			return 1'b0;
		return pm_map[gy][gx];
	endfunction

	function automatic ray_res_t cast_ray(ray_req_t q);
		ray_res_t r;
		int gx, gy, stx, sty, n;
		logic [23:0] dx, dy, ax, ay, d;
		logic [10:0] px, py;
		logic [35:0] p;
		logic hit, side;
		r = '0;
		if (q.op == grdda_pkg::OP_WRITE) begin
			pm_map[q.row] = q.walls;
			return r;
		end
		gx = int'(q.sx[15:10]);
		gy = int'(q.sy[15:10]);
		stx = q.hx[15] ? -1 : 1;
		sty = q.hy[15] ? -1 : 1;
		dx = recip(q.hx);
		dy = recip(q.hy);
		px = q.hx[15] ? {1'b0, q.sx[9:0]} : 11'd1024 - {1'b0, q.sx[9:0]};
		py = q.hy[15] ? {1'b0, q.sy[9:0]} : 11'd1024 - {1'b0, q.sy[9:0]};
		p = (36'(px) * 36'(dx)) >> 10;
		ax = (p > 36'(SAT)) ? SAT : p[23:0];
		p = (36'(py) * 36'(dy)) >> 10;
		ay = (p > 36'(SAT)) ? SAT : p[23:0];
		hit = 1'b0;
		side = 1'b0;
		d = SAT;
		n = 0;
		while (!hit && n < int'(pm_limit)) begin
			if (ax < ay) begin
				gx += stx;
				if (is_wall(gx, gy)) begin
					hit = 1'b1;
					side = grdda_pkg::AXIS_X;
					d = ax;
				end
				ax = sadd(ax, dx);
			end else begin
				gy += sty;
				if (is_wall(gx, gy)) begin
					hit = 1'b1;
					side = grdda_pkg::AXIS_Y;
					d = ay;
				end
				ay = sadd(ay, dy);
			end
			n++;
		end
		r.hit = hit;
		r.side = hit & side;
		r.wdist = d;
		r.cx = gx[9:0];
		r.cy = gy[9:0];
		r.steps = n[7:0];
		return r;
	endfunction

	task automatic report(string what, logic [23:0] got, logic [23:0] want);
		$display("mismatch beat %0d %s: got %0h want %0h", n_beats, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("timeout at cycle %0d", cycle);
			$display("[grid_ray_dda_traversal] ERROR");
			$finish;
		end
	end

	// receiver
	always @(posedge clk) begin
		ray_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_beats++;
			if (expected_q.size() == 0) begin
				$display("unexpected result beat %0d", n_beats);
				errors++;
			end else begin
				w = expected_q.pop_front();
				if (wall_hit !== w.hit)
					report("wall_hit", {23'd0, wall_hit}, {23'd0, w.hit});
				if (hit_side !== w.side)
					report("hit_side", {23'd0, hit_side}, {23'd0, w.side});
				if (wall_distance !== w.wdist)
					report("wall_distance", wall_distance, w.wdist);
				if (hit_cell_x !== w.cx)
					report("hit_cell_x", {14'd0, hit_cell_x}, {14'd0, w.cx});
				if (hit_cell_y !== w.cy)
					report("hit_cell_y", {14'd0, hit_cell_y}, {14'd0, w.cy});
				if (steps_used !== w.steps)
					report("steps_used", {16'd0, steps_used}, {16'd0, w.steps});
				if (w.hit) n_hits++;
			end
		end
		out_stall <= hold_rx || (!no_idle && $urandom_range(99) < 13);
	end

	task automatic send(ray_req_t q, logic known, ray_res_t want);
		ray_res_t p;
		while (!no_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		opcode <= q.op;
		row_select <= q.row;
		row_walls <= q.walls;
		start_x <= q.sx;
		start_y <= q.sy;
		heading_x <= q.hx;
		heading_y <= q.hy;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = cast_ray(q);
		if (known && p !== want) begin
			$display("directed row disagrees with predictor");
			errors++;
		end
		if (q.op == grdda_pkg::OP_CAST) n_casts++;
		expected_q.push_back(p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(grdda_pkg::cfg_idx_t idx, logic [7:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			grdda_pkg::CFG_MAP_COLUMNS: pm_cols = v[5:0];
			grdda_pkg::CFG_MAP_ROWS:    pm_rows = v[5:0];
			default:                    pm_limit = v;
		endcase
	endtask

	function automatic ray_req_t wr(logic [4:0] r, logic [31:0] w);
		ray_req_t q;
		q = '0;
		q.op = grdda_pkg::OP_WRITE;
		q.row = r;
		q.walls = w;
		q.sx = 16'($urandom);
		q.hy = 16'($urandom);
		return q;
	endfunction

	function automatic ray_req_t ray(logic [15:0] sx, logic [15:0] sy,
			logic [15:0] hx, logic [15:0] hy);
		ray_req_t q;
		q = '0;
		q.op = grdda_pkg::OP_CAST;
		q.sx = sx;
		q.sy = sy;
		q.hx = hx;
		q.hy = hy;
		q.walls = $urandom;
		return q;
	endfunction

	function automatic logic [15:0] rand_heading();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'($urandom_range(1, 16) * ($urandom_range(1) ? 1 : -1));
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic ray_req_t rand_item();
		if ($urandom_range(99) < 25)
			return wr(5'($urandom),
				($urandom_range(1)) ? $urandom : 32'h1 << $urandom_range(31));
		if ($urandom_range(9) == 0)
			return ray(16'($urandom), 16'($urandom), rand_heading(), rand_heading());
		return ray({6'($urandom_range(0, 33)), 10'($urandom)},
			{6'($urandom_range(0, 33)), 10'($urandom)}, rand_heading(), rand_heading());
	endfunction

	dir_row_t dir_tbl [$];

	task automatic add_row(ray_req_t q, logic known, ray_res_t r);
		dir_row_t d;
		d.req = q;
		d.known = known;
		d.res = r;
		dir_tbl.push_back(d);
	endtask

	initial begin
		pm_map = '{default: '0};
		pm_cols = grdda_pkg::MAP_COLUMNS_RST;
		pm_rows = grdda_pkg::MAP_ROWS_RST;
		pm_limit = grdda_pkg::STEP_LIMIT_RST;

		// empty map after reset: runs out the limit along +x
		add_row(ray(16'h0000, 16'h0000, 16'sd16384, 16'd0), 1'b1,
			'{1'b0, 1'b0, SAT, 10'd100, 10'd0, 8'd100});
		add_row(wr(5'd0, 32'hFFFF_FFFF), 1'b1, '0);
		add_row(wr(5'd31, 32'hFFFF_FFFF), 1'b1, '0);
		add_row(wr(5'd5, 32'h0000_0021), 1'b1, '0);
		// zero heading both axes
		add_row(ray(16'h0C00, 16'h0C00, 16'd0, 16'd0), 1'b0, '0);
		add_row(ray(16'hFFFF, 16'hFFFF, -16'sd16384, -16'sd16384), 1'b0, '0);
		add_row(ray(16'h0400, 16'h1600, 16'sd16384, 16'd0), 1'b0, '0);
		add_row(ray(16'h1600, 16'h1600, -16'sd16384, 16'sd1), 1'b0, '0);
		add_row(ray(16'h0800, 16'h0800, 16'sd11585, -16'sd11585), 1'b0, '0);
		add_row(ray(16'h0BFF, 16'h0001, 16'sd1, -16'sd1), 1'b0, '0);
		add_row(ray(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, '0);
		add_row(ray(16'h0400, 16'h1400, -16'sd16384, 16'd0), 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i])
			send(dir_tbl[i].req, dir_tbl[i].known, dir_tbl[i].res);
		drain();

		// extremes of the registers
		write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'd32);
		write_reg(grdda_pkg::CFG_MAP_ROWS, 8'd32);
		write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd255);
		send(ray(16'h0400, 16'h0400, -16'sd16384, -16'sd16384), 1'b0, '0);
		send(ray(16'h7C00, 16'h0400, 16'sd16384, 16'd0), 1'b0, '0);
		drain();
		write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'd63);
		write_reg(grdda_pkg::CFG_MAP_ROWS, 8'd1);
		write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd0);
		send(ray(16'h0400, 16'h0400, 16'sd16384, 16'd0), 1'b1,
			'{1'b0, 1'b0, SAT, 10'd1, 10'd1, 8'd0});
		drain();
		write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd1);
		send(ray(16'h0400, 16'h0400, 16'sd16384, 16'sd100), 1'b0, '0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'd24);
					write_reg(grdda_pkg::CFG_MAP_ROWS, 8'd24);
					write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd100); end
				1: begin write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'd1);
					write_reg(grdda_pkg::CFG_MAP_ROWS, 8'd33);
					write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd40); end
				2: begin write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'd32);
					write_reg(grdda_pkg::CFG_MAP_ROWS, 8'd32);
					write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'd255); end
				default: begin
					write_reg(grdda_pkg::CFG_MAP_COLUMNS, 8'($urandom_range(1, 63)));
					write_reg(grdda_pkg::CFG_MAP_ROWS, 8'($urandom_range(1, 63)));
					write_reg(grdda_pkg::CFG_STEP_LIMIT, 8'($urandom)); end
			endcase
			no_idle = (ph == 2);
			if (ph == 1) begin
				fork
					begin
						hold_rx = 1'b1;
						repeat (600) @(posedge clk);
						hold_rx = 1'b0;
					end
				join_none
			end
			for (int i = 0; i < N_RANDOM / 5; i++)
				send(rand_item(), 1'b0, '0);
			no_idle = 1'b0;
			drain();
		end

		$display("covered %0d casts, %0d walls hit, %0d result beats checked",
			n_casts, n_hits, n_beats);
		if (errors == 0)
			$display("[grid_ray_dda_traversal] OK");
		else
			$display("[grid_ray_dda_traversal] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/grdda_pkg.sv
hdl/grid_ray_dda_traversal.sv
tb/sv/grid_ray_dda_traversal_tb.sv
